// ----- rtl/asc_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_pkg: shared types and constants for the aux switch change scheduler
// Item layouts, quantizer divisors and the quantizer function.
// ----------------------------------------------------------------------------
`default_nettype none

package asc_pkg;

  localparam int IN_CH            = 8;
  localparam int RAW_W            = 11;
  localparam int STATE_W          = 3;
  localparam int IDX_W            = 4;
  localparam int ARM_W            = 3;
  localparam int FIRST_W          = 2;
  localparam int DIV_3BIT         = 300;
  localparam int DIV_2BIT         = 819;
  localparam int MAX_3BIT         = 7;
  localparam int MAX_2BIT         = 3;
  localparam int SWITCH_COUNT_DEF = 8;

  typedef struct packed {
    logic [RAW_W-1:0] switch_ch7;
    logic [RAW_W-1:0] switch_ch6;
    logic [RAW_W-1:0] switch_ch5;
    logic [RAW_W-1:0] switch_ch4;
    logic [RAW_W-1:0] switch_ch3;
    logic [RAW_W-1:0] switch_ch2;
    logic [RAW_W-1:0] switch_ch1;
    logic [RAW_W-1:0] switch_ch0;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   sent_index;
    logic [STATE_W-1:0] sent_value;
    logic [FIRST_W-1:0] first_value;
    logic               armed;
  } out_item_t;

  // threshold compares against constant multiples, capped at the mode maximum
  function automatic logic [STATE_W-1:0] quantize(input logic [RAW_W-1:0] raw,
                                                  input logic three_bit);
    logic [STATE_W-1:0] q;
    q = '0;
    for (int k = 1; k <= MAX_3BIT; k++) begin
      if (three_bit) begin
        if (int'(raw) >= k * DIV_3BIT) q = STATE_W'(k);
      end else if (k <= MAX_2BIT) begin
        if (int'(raw) >= k * DIV_2BIT) q = STATE_W'(k);
      end
    end
    return q;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/aux_switch_change_scheduler.sv -----
// ----------------------------------------------------------------------------
// aux_switch_change_scheduler: picks one aux switch per frame to send
// Path: an accepted item sits in the input register, then moves to the result register.
// Throughput: one item per cycle unless out_ready stalls; one combinational update pass.
// Reset (rst_n low, synchronous): switch states, change bitmap, rotate
// pointer, arm_switch and both valid flags clear.
// ----------------------------------------------------------------------------
`default_nettype none

module aux_switch_change_scheduler #(
  parameter int SWITCH_COUNT = asc_pkg::SWITCH_COUNT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire asc_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output asc_pkg::out_item_t              out_data,
  input  wire logic                       cfg_wr_en,
  input  wire logic [asc_pkg::ARM_W-1:0]  cfg_wr_data
);

  localparam int IN_CH   = asc_pkg::IN_CH;
  localparam int STATE_W = asc_pkg::STATE_W;
  localparam int IDX_W   = asc_pkg::IDX_W;
  localparam int RAW_W   = asc_pkg::RAW_W;
  localparam int ACTIVE  = (SWITCH_COUNT < IN_CH) ? SWITCH_COUNT : IN_CH;
  localparam bit SMALL   = (SWITCH_COUNT <= 5);
  localparam bit THREE   = (SWITCH_COUNT >= 6) && (SWITCH_COUNT <= 8);
  localparam logic [IN_CH-1:0]  ACT_MASK = IN_CH'((1 << ACTIVE) - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SWITCH_COUNT - 1);

  logic                  s1_valid_r;
  asc_pkg::in_item_t     s1_data_r;
  logic                  out_valid_r;
  asc_pkg::out_item_t    out_data_r, out_data_nxt;
  logic [STATE_W-1:0]    states_r [IN_CH];
  logic [STATE_W-1:0]    states_nxt [IN_CH];
  logic [IN_CH-1:0]      mask_r, mask_nxt;
  logic [IDX_W-1:0]      ptr_r, ptr_nxt;
  logic [asc_pkg::ARM_W-1:0] arm_r;

  logic                  s1_go;
  logic [RAW_W-1:0]      raw [IN_CH];
  logic [IN_CH-1:0]      pending;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [IDX_W-1:0]      ptr_inc;
  logic [STATE_W-1:0]    pick_value;

  assign s1_go     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign raw[0] = s1_data_r.switch_ch0;
  assign raw[1] = s1_data_r.switch_ch1;
  assign raw[2] = s1_data_r.switch_ch2;
  assign raw[3] = s1_data_r.switch_ch3;
  assign raw[4] = s1_data_r.switch_ch4;
  assign raw[5] = s1_data_r.switch_ch5;
  assign raw[6] = s1_data_r.switch_ch6;
  assign raw[7] = s1_data_r.switch_ch7;

  always_comb begin
    pending = mask_r;
    for (int i = 0; i < IN_CH; i++) begin
      states_nxt[i] = states_r[i];
      if (i < ACTIVE) begin
        states_nxt[i] = asc_pkg::quantize(raw[i], THREE);
        if (states_nxt[i] != states_r[i]) pending[i] = 1'b1;
      end
    end
    pending = pending & ACT_MASK;
    if (SMALL) pending[0] = 1'b0;

    // lowest pending switch wins
    found = 1'b0;
    pick  = '0;
    for (int i = IN_CH - 1; i >= 0; i--) begin
      if (pending[i]) begin
        found = 1'b1;
        pick  = IDX_W'(i);
      end
    end

    ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + 1'b1;
    if (SMALL && ptr_inc == '0) ptr_inc = IDX_W'(1);

    if (found) begin
      mask_nxt = pending & ~(IN_CH'(1) << pick);
      ptr_nxt  = ptr_r;
    end else begin
      pick     = ptr_r;
      mask_nxt = '0;
      ptr_nxt  = ptr_inc;
    end

    // switches beyond the input channels always read as zero
    pick_value = '0;
    for (int i = 0; i < IN_CH; i++) begin
      if (pick == IDX_W'(i)) pick_value = states_nxt[i];
    end

    out_data_nxt.sent_index  = pick;
    out_data_nxt.sent_value  = pick_value;
    out_data_nxt.first_value = SMALL ? states_nxt[0][asc_pkg::FIRST_W-1:0] : '0;
    out_data_nxt.armed       = (states_nxt[arm_r] != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mask_r      <= '0;
      ptr_r       <= '0;
      arm_r       <= '0;
      for (int i = 0; i < IN_CH; i++) states_r[i] <= '0;
    end else begin
      if (cfg_wr_en) arm_r <= cfg_wr_data;
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
        mask_r      <= mask_nxt;
        ptr_r       <= ptr_nxt;
        for (int i = 0; i < IN_CH; i++) states_r[i] <= states_nxt[i];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_data_r <= in_data;
    if (s1_go) out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.sent_index <= LAST_IDX))
    else $error("sent index beyond switch count");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> (ptr_r <= LAST_IDX))
    else $error("rotate pointer beyond switch count");

  a_mask_active: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> ((mask_r & ~ACT_MASK) == '0))
    else $error("change bit set for inactive switch");

  a_small_bit0: assert property (@(posedge clk) disable iff (!rst_n)
    (SMALL && s1_go) |=> !mask_r[0])
    else $error("switch 0 marked changed in small mode");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("item did not reach result register");
`endif

endmodule

`default_nettype wire

// ----- dv/aux_switch_change_scheduler_tb.sv -----
// ----------------------------------------------------------------------------
// aux_switch_change_scheduler_tb: self-checking bench for the switch scheduler
// Frames go in through a queued valid/ready driver and picks are checked
// against an in-bench predictor of the quantizer, change bitmap and round
// robin, under random idling, a long output hold-off and arm register changes.
// ----------------------------------------------------------------------------
module aux_switch_change_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_CH        = asc_pkg::IN_CH;
  localparam int RAW_W        = asc_pkg::RAW_W;
  localparam int STATE_W      = asc_pkg::STATE_W;
  localparam int IDX_W        = asc_pkg::IDX_W;
  localparam int ARM_W        = asc_pkg::ARM_W;
  localparam int FIRST_W      = asc_pkg::FIRST_W;
  localparam int SWITCH_COUNT = asc_pkg::SWITCH_COUNT_DEF;
  localparam int LIVE_CH      = (SWITCH_COUNT < IN_CH) ? SWITCH_COUNT : IN_CH;
  localparam bit FINE_STEPS   = (SWITCH_COUNT >= 6) && (SWITCH_COUNT <= 8);
  localparam bit SW0_APART    = (SWITCH_COUNT <= 5);
  localparam int STEP_DIV     = FINE_STEPS ? asc_pkg::DIV_3BIT : asc_pkg::DIV_2BIT;
  localparam int STEP_MAX     = FINE_STEPS ? asc_pkg::MAX_3BIT : asc_pkg::MAX_2BIT;
  localparam int RAW_TOP      = (1 << RAW_W) - 1;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 4;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  asc_pkg::in_item_t  in_data     = '0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  asc_pkg::out_item_t out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [ARM_W-1:0]   cfg_wr_data = '0;

  // predictor state
  logic [STATE_W-1:0] sw_state [IN_CH];
  logic [IN_CH-1:0]   change_map;
  logic [IDX_W-1:0]   rr_ptr;
  logic [ARM_W-1:0]   arm_sel;

  asc_pkg::in_item_t  frame_q [$];
  asc_pkg::out_item_t due_picks [$];
  int        held [IN_CH];
  logic      in_taken    = 1'b0;
  int        err_count   = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  logic      hold_go     = 1'b0;
  logic      hold_done   = 1'b0;
  int        hold_left   = 0;

  always #5 clk = ~clk;

  aux_switch_change_scheduler #(
    .SWITCH_COUNT(SWITCH_COUNT)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // quantize the frame, mark changes, then choose lowest change or next in rotation
  function automatic asc_pkg::out_item_t next_pick(input asc_pkg::in_item_t f);
    logic [IN_CH*RAW_W-1:0] flat;
    logic [STATE_W-1:0]     q;
    logic [IN_CH-1:0]       pending;
    int                     lvl;
    int                     sel;
    int                     nxt;
    asc_pkg::out_item_t     r;
    flat = f;
    for (int i = 0; i < LIVE_CH; i++) begin
      lvl = int'(flat[i*RAW_W +: RAW_W]) / STEP_DIV;
      if (lvl > STEP_MAX) lvl = STEP_MAX;
      q = STATE_W'(lvl);
      if (q != sw_state[i]) begin
        change_map[i] = 1'b1;
        sw_state[i]   = q;
      end
    end
    pending = change_map;
    if (SW0_APART) pending[0] = 1'b0;
    sel = IN_CH;
    for (int i = IN_CH - 1; i >= 0; i--) if (pending[i]) sel = i;
    if (sel >= IN_CH || sel >= SWITCH_COUNT) begin
      sel = int'(rr_ptr);
      nxt = (sel + 1) % SWITCH_COUNT;
      if (SW0_APART && nxt == 0) nxt = 1;
      rr_ptr     = IDX_W'(nxt);
      change_map = '0;
    end else begin
      pending[sel] = 1'b0;
      change_map   = pending;
    end
    r.sent_index = IDX_W'(sel);
    r.sent_value = '0;
    if (sel < IN_CH) r.sent_value = sw_state[sel];
    r.first_value = SW0_APART ? sw_state[0][FIRST_W-1:0] : '0;
    r.armed       = (sw_state[arm_sel] != '0);
    return r;
  endfunction

  function automatic asc_pkg::in_item_t pack_frame();
    logic [IN_CH*RAW_W-1:0] flat;
    for (int c = 0; c < IN_CH; c++) flat[c*RAW_W +: RAW_W] = RAW_W'(held[c]);
    return asc_pkg::in_item_t'(flat);
  endfunction

  // mostly held frames with a few channels moved, so changes drain and the rotation runs
  task automatic queue_frames(input int count);
    int kind;
    int v;
    int k;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        for (int c = 0; c < IN_CH; c++) held[c] = $urandom_range(0, RAW_TOP);
      end else if (kind < 30) begin
        // unchanged frame
      end else if (kind < 50) begin
        for (int c = 0; c < IN_CH; c++) begin
          v = held[c] + int'($urandom_range(0, 24)) - 12;
          held[c] = (v < 0) ? 0 : ((v > RAW_TOP) ? RAW_TOP : v);
        end
      end else begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 9) < 4) begin
            k = $urandom_range(1, STEP_MAX);
            v = k * STEP_DIV - int'($urandom_range(0, 1));
            held[$urandom_range(0, IN_CH - 1)] = (v > RAW_TOP) ? RAW_TOP : v;
          end else begin
            held[$urandom_range(0, IN_CH - 1)] = $urandom_range(0, RAW_TOP);
          end
        end
      end
      frame_q.push_back(pack_frame());
    end
  endtask

  task automatic wait_for_quiet();
    while (frame_q.size() != 0) @(negedge clk);
    @(negedge clk);
    while (in_valid || due_picks.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_arm(input logic [ARM_W-1:0] v);
    wait_for_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (frame_q.size() != 0 &&
          !(tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)) begin
        in_data  <= frame_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : watch_ports
    asc_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < IN_CH; i++) sw_state[i] = '0;
      change_map = '0;
      rr_ptr     = '0;
      arm_sel    = '0;
      in_taken   <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_wr_en) arm_sel = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (due_picks.size() == 0) begin
          if (err_count < 10)
            $display("%0t: unexpected pick idx %0d val %0d first %0d armed %0b", $realtime,
                     out_data.sent_index, out_data.sent_value, out_data.first_value,
                     out_data.armed);
          err_count++;
        end else begin
          want = due_picks.pop_front();
          if (want.sent_index !== out_data.sent_index ||
              want.sent_value !== out_data.sent_value ||
              want.first_value !== out_data.first_value ||
              want.armed !== out_data.armed) begin
            if (err_count < 10)
              $display({"%0t: pick mismatch exp idx %0d val %0d first %0d armed %0b,",
                        " got %0d %0d %0d %0b"},
                       $realtime, want.sent_index, want.sent_value, want.first_value,
                       want.armed, out_data.sent_index, out_data.sent_value,
                       out_data.first_value, out_data.armed);
            err_count++;
          end
        end
      end
      if (in_valid && in_ready) due_picks.push_back(next_pick(in_data));
    end
  end

  initial begin : stimulus
    int v;
    for (int c = 0; c < IN_CH; c++) held[c] = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // quiet frame: first rotation pick straight after reset
    frame_q.push_back(pack_frame());
    // full scale everywhere, then let the changes drain lowest first
    for (int c = 0; c < IN_CH; c++) held[c] = RAW_TOP;
    repeat (8) frame_q.push_back(pack_frame());
    repeat (3) frame_q.push_back(pack_frame());
    // step thresholds, just on and just below
    for (int c = 0; c < IN_CH; c++) begin
      v = c * STEP_DIV;
      held[c] = (v > RAW_TOP) ? RAW_TOP : v;
    end
    frame_q.push_back(pack_frame());
    for (int c = 0; c < IN_CH; c++) begin
      v = c * STEP_DIV - 1;
      held[c] = (v < 0) ? 0 : ((v > RAW_TOP) ? RAW_TOP : v);
    end
    frame_q.push_back(pack_frame());
    // alternating bit patterns, then swapped
    for (int c = 0; c < IN_CH; c++) held[c] = (c % 2) ? 'h555 : 'h2AA;
    frame_q.push_back(pack_frame());
    for (int c = 0; c < IN_CH; c++) held[c] = (c % 2) ? 'h2AA : 'h555;
    frame_q.push_back(pack_frame());
    // one switch moves alone, then switch 0 alone
    held[5] = 0;
    frame_q.push_back(pack_frame());
    held[0] = RAW_TOP;
    frame_q.push_back(pack_frame());
    // long quiet run wraps the rotation
    repeat (6) frame_q.push_back(pack_frame());

    write_arm(ARM_W'(IN_CH - 1));
    tx_idle_pct <= 20;
    rx_idle_pct <= 20;
    queue_frames(250);

    // no idling, and the output stalls long enough to back up the input
    write_arm('0);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    hold_go     <= 1'b1;
    queue_frames(200);

    write_arm(ARM_W'($urandom_range(1, IN_CH - 2)));
    tx_idle_pct <= 20;
    rx_idle_pct <= 20;
    queue_frames(120);
    wait_for_quiet();
    queue_frames(130);

    write_arm(ARM_W'(3));
    queue_frames(250);
    wait_for_quiet();

    if (err_count == 0 && due_picks.size() == 0) begin
      $display("** aux_switch_change_scheduler: PASSED **");
    end else begin
      $display("** aux_switch_change_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("** aux_switch_change_scheduler: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/asc_pkg.sv
rtl/aux_switch_change_scheduler.sv
dv/aux_switch_change_scheduler_tb.sv
